// File: rtl/core/flsa_pkg.sv
// ----------------------------------------------------------------------------
// Free list slot allocator package
// Shared types and fixed sizes for the slot allocator and its link memory.
// ----------------------------------------------------------------------------
package flsa_pkg;

   // Pool limits. The request and result field widths are built around them.
   localparam int MAX_CHUNKS          = 8;
   localparam int MAX_SLOTS_PER_CHUNK = 64;
   localparam int MAX_SLOT_BYTES      = 4096;

   localparam int CAPACITY = MAX_CHUNKS * MAX_SLOTS_PER_CHUNK;

   // Field widths.
   localparam int ADDR_W   = 21;
   localparam int RES_W    = 22;
   localparam int COUNT_W  = 10;
   localparam int CHUNKS_W = 4;
   localparam int SB_W     = 13;
   localparam int SPC_W    = 7;
   localparam int STATUS_W = 2;

   // Link memory geometry. A link value of CAPACITY marks the end of the list.
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LINK_W = $clog2(CAPACITY + 1);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

   // Bytes in one chunk at the largest register settings.
   localparam int CHUNK_BYTES_W = $clog2(MAX_SLOTS_PER_CHUNK * MAX_SLOT_BYTES + 1);

   // Request codes.
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_SLOT_BYTES     = 1'b0;
   localparam logic CSR_SLOTS_IN_CHUNK = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] free_addr;
   } flsa_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   slot_addr;
      logic [COUNT_W-1:0]  used_count;
      logic [COUNT_W-1:0]  free_count;
      logic [CHUNKS_W-1:0] chunks_in_use;
      logic [RES_W-1:0]    reserved_bytes;
   } flsa_rsp_type;

endpackage

// File: rtl/core/flsa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module flsa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/free_list_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Free list slot allocator
// Hands out fixed-size slots from a pool that grows one chunk at a time and
// takes them back on a linked free list held in a link memory.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                              Transfer
//  request   start, busy, req_data              start high while busy is low
//  result    rsp_valid, rsp_data                one-cycle strobe, no stall
//  config    csr_valid, csr_ready, csr_index,   valid and ready both high
//            csr_wdata
//
// An allocate from a non-empty list passes the pop and completion states to
// the result strobe; one that grows the pool first writes one link per new
// slot. A free inside the pool runs the 9-step restoring divider, then the
// push; an exhausted allocate or a free beyond the pool goes straight to
// completion. Busy drops in the strobe cycle and the receiver never stalls.
// Reset is synchronous; it restores 64-byte slots, 64-slot chunks and an
// empty pool. A configuration write also empties the pool.
//
module free_list_slot_allocator_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  flsa_pkg::flsa_req_type req_data,
   output logic                  rsp_valid,
   output flsa_pkg::flsa_rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [12:0]           csr_wdata
);

   import flsa_pkg::*;

   localparam int QUO_W  = IDX_W;
   localparam int STEP_W = $clog2(QUO_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_ALLOC_RD,
      ST_POP,
      ST_DIV,
      ST_PUSH,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [SB_W-1:0]           slot_bytes_ff, slot_bytes_in;
   logic [SPC_W-1:0]          spc_ff, spc_in;
   logic [CHUNK_BYTES_W-1:0]  chunk_bytes_ff, chunk_bytes_in;
   logic [LINK_W-1:0]         head_ff, head_in;
   logic [CHUNKS_W-1:0]       chunk_count_ff, chunk_count_in;
   logic [COUNT_W-1:0]        cap_ff, cap_in;
   logic [RES_W-1:0]          reserved_ff, reserved_in;
   logic [COUNT_W-1:0]        used_ff, used_in;
   logic [COUNT_W-1:0]        free_ff, free_in;
   logic [LINK_W-1:0]         ptr_ff, ptr_in;
   logic [SPC_W-2:0]          exp_cnt_ff, exp_cnt_in;
   logic [ADDR_W-1:0]         rem_ff, rem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   flsa_rsp_type              rsp_ff, rsp_in;

   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [LINK_W-1:0]         ram_wdata;
   logic [LINK_W-1:0]         ram_rdata;

   logic [COUNT_W-1:0]        cap_grown;
   logic [COUNT_W:0]          free_sum;
   logic [ADDR_W-1:0]         trial;
   logic [LINK_W+SB_W-1:0]    prod_full;
   logic [SB_W+SPC_W-1:0]     chunk_prod;

   // The link memory is always read at the list head; a pop uses the read data
   // in the cycle after the head has settled.
   flsa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cap_grown  = cap_ff + COUNT_W'(spc_ff);
   assign free_sum   = {1'b0, free_ff} + (COUNT_W + 1)'(spc_ff);
   assign trial      = ADDR_W'(slot_bytes_ff) << step_ff;
   assign prod_full  = (LINK_W + SB_W)'(head_ff) * (LINK_W + SB_W)'(slot_bytes_ff);
   assign chunk_prod = (SB_W + SPC_W)'(slot_bytes_ff) * (SB_W + SPC_W)'(spc_ff);

   always_comb begin
      state_in       = state_ff;
      slot_bytes_in  = slot_bytes_ff;
      spc_in         = spc_ff;
      chunk_bytes_in = chunk_prod[CHUNK_BYTES_W-1:0];
      head_in        = head_ff;
      chunk_count_in = chunk_count_ff;
      cap_in         = cap_ff;
      reserved_in    = reserved_ff;
      used_in        = used_ff;
      free_in        = free_ff;
      ptr_in         = ptr_ff;
      exp_cnt_in     = exp_cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      ram_we         = 1'b0;
      ram_waddr      = ptr_ff[IDX_W-1:0];
      ram_wdata      = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in   = '0;
               status_in = STATUS_OK;
               if (req_data.req_type == REQ_ALLOC) begin
                  if (head_ff == NULL_LINK) begin
                     if (chunk_count_ff < CHUNKS_W'(MAX_CHUNKS)) begin
                        ptr_in     = cap_ff;
                        exp_cnt_in = '0;
                        state_in   = ST_EXPAND;
                     end else begin
                        status_in = STATUS_EXHAUSTED;
                        state_in  = ST_DONE;
                     end
                  end else begin
                     state_in = ST_POP;
                  end
               end else begin
                  if ({1'b0, req_data.free_addr} >= reserved_ff) begin
                     status_in = STATUS_BAD_ADDR;
                     state_in  = ST_DONE;
                  end else begin
                     rem_in   = req_data.free_addr;
                     quo_in   = '0;
                     step_in  = STEP_W'(QUO_W - 1);
                     state_in = ST_DIV;
                  end
               end
            end else if (csr_valid) begin
               // Either register write clamps its value and empties the pool.
               if (csr_index == CSR_SLOT_BYTES) begin
                  if (csr_wdata == '0) begin
                     slot_bytes_in = SB_W'(1);
                  end else if (csr_wdata > SB_W'(MAX_SLOT_BYTES)) begin
                     slot_bytes_in = SB_W'(MAX_SLOT_BYTES);
                  end else begin
                     slot_bytes_in = csr_wdata;
                  end
               end else begin
                  if (csr_wdata[SPC_W-1:0] == '0) begin
                     spc_in = SPC_W'(1);
                  end else if (csr_wdata[SPC_W-1:0] > SPC_W'(MAX_SLOTS_PER_CHUNK)) begin
                     spc_in = SPC_W'(MAX_SLOTS_PER_CHUNK);
                  end else begin
                     spc_in = csr_wdata[SPC_W-1:0];
                  end
               end
               head_in        = NULL_LINK;
               chunk_count_in = '0;
               cap_in         = '0;
               reserved_in    = '0;
               used_in        = '0;
               free_in        = '0;
            end
         end

         ST_EXPAND: begin
            // Each new slot links to the previous head, so the top slot of the
            // chunk ends up first on the list.
            ram_we     = 1'b1;
            ram_waddr  = ptr_ff[IDX_W-1:0];
            ram_wdata  = head_ff;
            head_in    = ptr_ff;
            ptr_in     = ptr_ff + LINK_W'(1);
            exp_cnt_in = exp_cnt_ff + (SPC_W - 1)'(1);
            if ({1'b0, exp_cnt_ff} == spc_ff - SPC_W'(1)) begin
               chunk_count_in = chunk_count_ff + CHUNKS_W'(1);
               cap_in         = cap_grown;
               reserved_in    = reserved_ff + RES_W'(chunk_bytes_ff);
               if (free_sum > {1'b0, cap_grown}) begin
                  free_in = cap_grown;
               end else begin
                  free_in = free_sum[COUNT_W-1:0];
               end
               state_in = ST_ALLOC_RD;
            end
         end

         ST_ALLOC_RD: begin
            state_in = ST_POP;
         end

         ST_POP: begin
            if (ram_rdata > NULL_LINK) begin
               head_in = NULL_LINK;
            end else begin
               head_in = ram_rdata;
            end
            if (used_ff < cap_ff) begin
               used_in = used_ff + COUNT_W'(1);
            end
            if (free_ff != '0) begin
               free_in = free_ff - COUNT_W'(1);
            end
            addr_in   = prod_full[ADDR_W-1:0];
            status_in = STATUS_OK;
            state_in  = ST_DONE;
         end

         ST_DIV: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end

         ST_PUSH: begin
            if (rem_ff != '0) begin
               status_in = STATUS_BAD_ADDR;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = quo_ff;
               ram_wdata = head_ff;
               head_in   = LINK_W'(quo_ff);
               if (free_ff < cap_ff) begin
                  free_in = free_ff + COUNT_W'(1);
               end
               if (used_ff != '0) begin
                  used_in = used_ff - COUNT_W'(1);
               end
               status_in = STATUS_OK;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = status_ff;
            rsp_in.slot_addr      = addr_ff;
            rsp_in.used_count     = used_ff;
            rsp_in.free_count     = free_ff;
            rsp_in.chunks_in_use  = chunk_count_ff;
            rsp_in.reserved_bytes = reserved_ff;
            state_in              = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         slot_bytes_ff  <= SB_W'(64);
         spc_ff         <= SPC_W'(64);
         head_ff        <= NULL_LINK;
         chunk_count_ff <= '0;
         cap_ff         <= '0;
         reserved_ff    <= '0;
         used_ff        <= '0;
         free_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_bytes_ff  <= slot_bytes_in;
         spc_ff         <= spc_in;
         head_ff        <= head_in;
         chunk_count_ff <= chunk_count_in;
         cap_ff         <= cap_in;
         reserved_ff    <= reserved_in;
         used_ff        <= used_in;
         free_ff        <= free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      chunk_bytes_ff <= chunk_bytes_in;
      ptr_ff         <= ptr_in;
      exp_cnt_ff     <= exp_cnt_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      step_ff        <= step_in;
      status_ff      <= status_in;
      addr_ff        <= addr_in;
      rsp_ff         <= rsp_in;
   end

`ifndef ASSERT_OFF
   // A result strobe comes only out of the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("result strobe without a finished transaction");

   // An accepted request always keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

   // Counts never exceed the reserved capacity.
   a_counts_in_cap: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= cap_ff) && (free_ff <= cap_ff))
      else $error("slot count above capacity");

   // The pool grows only while chunks remain.
   a_expand_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPAND) |-> (chunk_count_ff < CHUNKS_W'(MAX_CHUNKS)))
      else $error("expansion beyond the chunk limit");

   // A slot pushed back by a free lies inside the capacity.
   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PUSH) && (rem_ff == '0)) |-> (LINK_W'(quo_ff) < cap_ff))
      else $error("freed slot index outside the pool");
`endif

endmodule
